// File: src/iaa_pkg.sv
// ----------------------------------------------------------------------------
// Interval ALU package
// Shared widths, codes, word types and the saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package iaa_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned LANES = 4;

  typedef logic signed [VALUE_WIDTH-1:0]   val_t;
  typedef logic signed [2*VALUE_WIDTH-1:0] wide_t;
  typedef logic        [VALUE_WIDTH-1:0]   mag_t;

  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_NEG = 3'd4,
    KIND_ABS = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_OVF  = 2'd1,
    STATUS_DIVZ = 2'd2
  } status_e;

  localparam val_t VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [2:0] kind;
    val_t       a_low;
    val_t       a_high;
    val_t       b_low;
    val_t       b_high;
  } in_t;

  typedef struct packed {
    val_t       res_low;
    val_t       res_high;
    logic [1:0] status;
  } out_t;

  typedef struct packed {
    logic ovf;
    val_t val;
  } sat_t;

  // One lane of the restoring divider.
  typedef struct packed {
    mag_t rem;
    mag_t dvd;
    mag_t dvs;
  } dlane_t;

  typedef dlane_t [LANES-1:0] dvec_t;

  // Everything that travels alongside the divider.
  typedef struct packed {
    logic [2:0]                              kind;
    logic [LANES-1:0]                        neg;
    logic [LANES-1:0][2*VALUE_WIDTH-1:0]     prod;
    val_t                                    lo;
    val_t                                    hi;
    logic                                    ovf;
    logic                                    divz;
  } side_t;

  function automatic sat_t saturate(input wide_t x);
    sat_t r;
    r.ovf = 1'b0;
    r.val = x[VALUE_WIDTH-1:0];
    if (x > wide_t'(VAL_MAX)) begin
      r.ovf = 1'b1;
      r.val = VAL_MAX;
    end else if (x < wide_t'(VAL_MIN)) begin
      r.ovf = 1'b1;
      r.val = VAL_MIN;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/iaa_front.sv
// ----------------------------------------------------------------------------
// Interval ALU front end
// Orders both operands, then forms end products, divider operands and the
// results of the additive and unary operations.
// ----------------------------------------------------------------------------
`default_nettype none

module iaa_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  iaa_pkg::in_t       data_i,
  output logic               valid_o,
  output iaa_pkg::side_t     side_o,
  output iaa_pkg::dvec_t     dv_o
);
  import iaa_pkg::*;

  in_t   ord_d, ord_q;
  logic  vld_a_q, vld_b_q;
  side_t side_d, side_q;
  dvec_t dv_d, dv_q;

  always_comb begin
    ord_d = data_i;
    if (data_i.a_low > data_i.a_high) begin
      ord_d.a_low  = data_i.a_high;
      ord_d.a_high = data_i.a_low;
    end
    if (data_i.b_low > data_i.b_high) begin
      ord_d.b_low  = data_i.b_high;
      ord_d.b_high = data_i.b_low;
    end
  end

  always_comb begin
    val_t x [LANES];
    val_t y [LANES];
    sat_t s0, s1;
    x[0] = ord_q.a_low;  y[0] = ord_q.b_low;
    x[1] = ord_q.a_low;  y[1] = ord_q.b_high;
    x[2] = ord_q.a_high; y[2] = ord_q.b_low;
    x[3] = ord_q.a_high; y[3] = ord_q.b_high;
    side_d.kind = ord_q.kind;
    for (int l = 0; l < LANES; l++) begin
      side_d.prod[l] = wide_t'(x[l]) * wide_t'(y[l]);
      side_d.neg[l]  = x[l][VALUE_WIDTH-1] ^ y[l][VALUE_WIDTH-1];
      dv_d[l].rem    = '0;
      dv_d[l].dvd    = x[l][VALUE_WIDTH-1] ? mag_t'(-x[l]) : mag_t'(x[l]);
      dv_d[l].dvs    = y[l][VALUE_WIDTH-1] ? mag_t'(-y[l]) : mag_t'(y[l]);
    end
    side_d.divz = (ord_q.b_low <= 0) && (ord_q.b_high >= 0);
    s0 = saturate(-wide_t'(ord_q.a_high));
    s1 = saturate(-wide_t'(ord_q.a_low));
    side_d.lo  = ord_q.a_low;
    side_d.hi  = ord_q.a_high;
    side_d.ovf = 1'b0;
    unique case (ord_q.kind)
      KIND_ADD: begin
        s0 = saturate(wide_t'(ord_q.a_low) + wide_t'(ord_q.b_low));
        s1 = saturate(wide_t'(ord_q.a_high) + wide_t'(ord_q.b_high));
        side_d.lo  = s0.val;
        side_d.hi  = s1.val;
        side_d.ovf = s0.ovf | s1.ovf;
      end
      KIND_SUB: begin
        s0 = saturate(wide_t'(ord_q.a_low) - wide_t'(ord_q.b_high));
        s1 = saturate(wide_t'(ord_q.a_high) - wide_t'(ord_q.b_low));
        side_d.lo  = s0.val;
        side_d.hi  = s1.val;
        side_d.ovf = s0.ovf | s1.ovf;
      end
      KIND_NEG: begin
        side_d.lo  = s0.val;
        side_d.hi  = s1.val;
        side_d.ovf = s0.ovf | s1.ovf;
      end
      KIND_ABS: begin
        if (ord_q.a_high < 0) begin
          side_d.lo  = s0.val;
          side_d.hi  = s1.val;
          side_d.ovf = s0.ovf | s1.ovf;
        end else if (ord_q.a_low < 0) begin
          side_d.lo  = '0;
          side_d.hi  = (s1.val > ord_q.a_high) ? s1.val : ord_q.a_high;
          side_d.ovf = s1.ovf;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= valid_i;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ord_q  <= ord_d;
      side_q <= side_d;
      dv_q   <= dv_d;
    end
  end

  assign valid_o = vld_b_q;
  assign side_o  = side_q;
  assign dv_o    = dv_q;

endmodule

`default_nettype wire

// File: src/iaa_div_pipe.sv
// ----------------------------------------------------------------------------
// Interval ALU divider pipeline
// Four unsigned restoring dividers, one quotient bit per stage, with the
// rest of the word carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module iaa_div_pipe (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          en_i,
  input  wire logic                                          valid_i,
  input  iaa_pkg::side_t                                     side_i,
  input  iaa_pkg::dvec_t                                     dv_i,
  output logic                                               valid_o,
  output iaa_pkg::side_t                                     side_o,
  output logic [iaa_pkg::LANES-1:0][iaa_pkg::VALUE_WIDTH-1:0] quot_o
);
  import iaa_pkg::*;

  logic [VALUE_WIDTH-1:0] vld_q;
  dvec_t                  stg_d [VALUE_WIDTH];
  dvec_t                  stg_q [VALUE_WIDTH];
  side_t                  side_q [VALUE_WIDTH];

  function automatic dlane_t div_step(input dlane_t s);
    dlane_t           r;
    logic [VALUE_WIDTH:0] t;
    logic [VALUE_WIDTH:0] d;
    t     = {s.rem, s.dvd[VALUE_WIDTH-1]};
    d     = t - {1'b0, s.dvs};
    r     = s;
    r.rem = d[VALUE_WIDTH] ? t[VALUE_WIDTH-1:0] : d[VALUE_WIDTH-1:0];
    r.dvd = {s.dvd[VALUE_WIDTH-2:0], ~d[VALUE_WIDTH]};
    return r;
  endfunction

  always_comb begin
    for (int k = 0; k < VALUE_WIDTH; k++) begin
      for (int l = 0; l < LANES; l++) begin
        if (k == 0) begin
          stg_d[k][l] = div_step(dv_i[l]);
        end else begin
          stg_d[k][l] = div_step(stg_q[k-1][l]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[VALUE_WIDTH-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < VALUE_WIDTH; k++) begin
        stg_q[k] <= stg_d[k];
        if (k == 0) begin
          side_q[k] <= side_i;
        end else begin
          side_q[k] <= side_q[k-1];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quot_o[l] = stg_q[VALUE_WIDTH-1][l].dvd;
    end
  end

  assign valid_o = vld_q[VALUE_WIDTH-1];
  assign side_o  = side_q[VALUE_WIDTH-1];

endmodule

`default_nettype wire

// File: src/iaa_back.sv
// ----------------------------------------------------------------------------
// Interval ALU back end
// Signs the quotients and saturates the four end values, then takes their minimum and
// maximum and selects the result word and status.
// ----------------------------------------------------------------------------
`default_nettype none

module iaa_back (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          en_i,
  input  wire logic                                          valid_i,
  input  iaa_pkg::side_t                                     side_i,
  input  wire logic [iaa_pkg::LANES-1:0][iaa_pkg::VALUE_WIDTH-1:0] quot_i,
  output logic                                               valid_o,
  output iaa_pkg::out_t                                      data_o
);
  import iaa_pkg::*;

  typedef struct packed {
    logic [2:0]                        kind;
    logic [LANES-1:0][VALUE_WIDTH-1:0] v;
    logic [LANES-1:0]                  lane_ovf;
    val_t                              lo;
    val_t                              hi;
    logic                              ovf;
    logic                              divz;
  } mid_t;

  mid_t mid_d, mid_q;
  out_t out_d, out_q;
  logic vld_c_q, vld_d_q;

  always_comb begin
    wide_t w;
    sat_t  s;
    mid_d.kind = side_i.kind;
    mid_d.lo   = side_i.lo;
    mid_d.hi   = side_i.hi;
    mid_d.ovf  = side_i.ovf;
    mid_d.divz = side_i.divz;
    for (int l = 0; l < LANES; l++) begin
      if (side_i.kind == KIND_MUL) begin
        w = wide_t'(side_i.prod[l]);
      end else begin
        w = wide_t'({1'b0, quot_i[l]});
        if (side_i.neg[l]) begin
          w = -w;
        end
      end
      s                 = saturate(w);
      mid_d.v[l]        = s.val;
      mid_d.lane_ovf[l] = s.ovf;
    end
  end

  always_comb begin
    val_t mn01, mn23, mx01, mx23, mn, mx;
    val_t v0, v1, v2, v3;
    v0   = mid_q.v[0];
    v1   = mid_q.v[1];
    v2   = mid_q.v[2];
    v3   = mid_q.v[3];
    mn01 = (v1 < v0) ? v1 : v0;
    mx01 = (v1 > v0) ? v1 : v0;
    mn23 = (v3 < v2) ? v3 : v2;
    mx23 = (v3 > v2) ? v3 : v2;
    mn   = (mn23 < mn01) ? mn23 : mn01;
    mx   = (mx23 > mx01) ? mx23 : mx01;
    out_d.res_low  = mid_q.lo;
    out_d.res_high = mid_q.hi;
    out_d.status   = mid_q.ovf ? STATUS_OVF : STATUS_OK;
    unique case (mid_q.kind)
      KIND_MUL: begin
        out_d.res_low  = mn;
        out_d.res_high = mx;
        out_d.status   = (|mid_q.lane_ovf) ? STATUS_OVF : STATUS_OK;
      end
      KIND_DIV: begin
        if (mid_q.divz) begin
          out_d.res_low  = VAL_MIN;
          out_d.res_high = VAL_MAX;
          out_d.status   = STATUS_DIVZ;
        end else begin
          out_d.res_low  = mn;
          out_d.res_high = mx;
          out_d.status   = (|mid_q.lane_ovf) ? STATUS_OVF : STATUS_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
    end else if (en_i) begin
      vld_c_q <= valid_i;
      vld_d_q <= vld_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_q <= mid_d;
      out_q <= out_d;
    end
  end

  assign valid_o = vld_d_q;
  assign data_o  = out_q;

endmodule

`default_nettype wire

// File: src/interval_arithmetic_alu_top.sv
// ----------------------------------------------------------------------------
// Interval arithmetic ALU
// Most of the pipeline depth is the divider, which retires one quotient bit
// per stage, between the front and back ends.
// Throughput is one word per cycle; a stalled output holds the whole pipe.
// Reset clears all valid bits, so the pipe comes up empty.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_arithmetic_alu_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  iaa_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output iaa_pkg::out_t   out_data_o
);
  import iaa_pkg::*;

  logic  adv;
  logic  fe_valid, dp_valid;
  side_t fe_side, dp_side;
  dvec_t fe_dv;
  logic [LANES-1:0][VALUE_WIDTH-1:0] dp_quot;

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  iaa_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (fe_valid),
    .side_o  (fe_side),
    .dv_o    (fe_dv)
  );

  iaa_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (fe_valid),
    .side_i  (fe_side),
    .dv_i    (fe_dv),
    .valid_o (dp_valid),
    .side_o  (dp_side),
    .quot_o  (dp_quot)
  );

  iaa_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (dp_valid),
    .side_i  (dp_side),
    .quot_i  (dp_quot),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// File: verif/interval_arithmetic_alu_checker.sv
// ----------------------------------------------------------------------------
// Interval ALU checker
// Watches both channels, predicts each result word from the accepted input
// word and compares it field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module interval_arithmetic_alu_checker (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_stall_i,
  input  iaa_pkg::in_t   in_data_i,
  input  wire logic      out_valid_i,
  input  wire logic      out_stall_i,
  input  iaa_pkg::out_t  out_data_i,
  output int             fail_count_o,
  output int             pending_o
);
  import iaa_pkg::*;

  typedef logic signed [VALUE_WIDTH+1:0] ext_t;

  out_t results_q[$];

  function automatic val_t clamp(input ext_t x, inout logic ovf);
    if (x > ext_t'(VAL_MAX)) begin
      ovf = 1'b1;
      return VAL_MAX;
    end
    if (x < ext_t'(VAL_MIN)) begin
      ovf = 1'b1;
      return VAL_MIN;
    end
    return val_t'(x);
  endfunction

  function automatic out_t interval_result(input in_t w);
    val_t al, ah, bl, bh, t, lo, hi;
    logic signed [2*VALUE_WIDTH+1:0] p [4];
    logic signed [2*VALUE_WIDTH+1:0] pl, ph;
    logic ovf;
    logic [1:0] st;
    out_t r;
    al = w.a_low; ah = w.a_high; bl = w.b_low; bh = w.b_high;
    if (al > ah) begin t = al; al = ah; ah = t; end
    if (bl > bh) begin t = bl; bl = bh; bh = t; end
    lo = al; hi = ah; ovf = 1'b0; st = STATUS_OK;
    case (w.kind)
      KIND_ADD: begin
        lo = clamp(ext_t'(al) + ext_t'(bl), ovf);
        hi = clamp(ext_t'(ah) + ext_t'(bh), ovf);
      end
      KIND_SUB: begin
        lo = clamp(ext_t'(al) - ext_t'(bh), ovf);
        hi = clamp(ext_t'(ah) - ext_t'(bl), ovf);
      end
      KIND_MUL, KIND_DIV: begin
        if (w.kind == KIND_DIV && bl <= 0 && bh >= 0) begin
          lo = VAL_MIN; hi = VAL_MAX; st = STATUS_DIVZ;
        end else begin
          if (w.kind == KIND_MUL) begin
            for (int i = 0; i < 4; i++) begin
              p[i] = (i < 2 ? $signed({{(VALUE_WIDTH+2){al[VALUE_WIDTH-1]}}, al})
                            : $signed({{(VALUE_WIDTH+2){ah[VALUE_WIDTH-1]}}, ah}))
                   * (i[0] ? $signed({{(VALUE_WIDTH+2){bh[VALUE_WIDTH-1]}}, bh})
                           : $signed({{(VALUE_WIDTH+2){bl[VALUE_WIDTH-1]}}, bl}));
            end
          end else begin
            p[0] = (2*VALUE_WIDTH+2)'(al) / (2*VALUE_WIDTH+2)'(bl);
            p[1] = (2*VALUE_WIDTH+2)'(al) / (2*VALUE_WIDTH+2)'(bh);
            p[2] = (2*VALUE_WIDTH+2)'(ah) / (2*VALUE_WIDTH+2)'(bl);
            p[3] = (2*VALUE_WIDTH+2)'(ah) / (2*VALUE_WIDTH+2)'(bh);
          end
          pl = p[0]; ph = p[0];
          for (int i = 1; i < 4; i++) begin
            if (p[i] < pl) pl = p[i];
            if (p[i] > ph) ph = p[i];
          end
          for (int i = 0; i < 4; i++)
            if (p[i] > VAL_MAX || p[i] < VAL_MIN) ovf = 1'b1;
          lo = pl > VAL_MAX ? VAL_MAX : pl < VAL_MIN ? VAL_MIN : val_t'(pl);
          hi = ph > VAL_MAX ? VAL_MAX : ph < VAL_MIN ? VAL_MIN : val_t'(ph);
        end
      end
      KIND_NEG: begin
        lo = clamp(-ext_t'(ah), ovf);
        hi = clamp(-ext_t'(al), ovf);
      end
      KIND_ABS: begin
        if (ah < 0) begin
          lo = clamp(-ext_t'(ah), ovf);
          hi = clamp(-ext_t'(al), ovf);
        end else if (al < 0) begin
          t = clamp(-ext_t'(al), ovf);
          lo = '0;
          hi = t > ah ? t : ah;
        end
      end
      default: ;
    endcase
    if (st == STATUS_OK && ovf) st = STATUS_OVF;
    r.res_low = lo; r.res_high = hi; r.status = st;
    return r;
  endfunction

  assign pending_o = results_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    out_t exp_w;
    int   errs;
    if (!rst_ni) begin
      fail_count_o <= 0;
      results_q.delete();
    end else begin
      errs = 0;
      if (in_valid_i && !in_stall_i) results_q.push_back(interval_result(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (results_q.size() == 0) begin
          $error("Result word arrived with nothing expected");
          errs++;
        end else begin
          exp_w = results_q.pop_front();
          if (out_data_i.res_low !== exp_w.res_low) begin
            $error("res_low expected %0d actual %0d", exp_w.res_low, out_data_i.res_low);
            errs++;
          end
          if (out_data_i.res_high !== exp_w.res_high) begin
            $error("res_high expected %0d actual %0d", exp_w.res_high, out_data_i.res_high);
            errs++;
          end
          if (out_data_i.status !== exp_w.status) begin
            $error("status expected %0d actual %0d", exp_w.status, out_data_i.status);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
    end
  end

endmodule

`default_nettype wire

// File: verif/interval_arithmetic_alu_top_tb.sv
// ----------------------------------------------------------------------------
// Interval ALU testbench
// Drives directed corner words and then random interval operations with
// random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module interval_arithmetic_alu_top_tb;
  import iaa_pkg::*;

  localparam int LATENCY = VALUE_WIDTH + 4;
  localparam int WATCHDOG_LIMIT = 20 * LATENCY + 2000;
  localparam int RANDOM_WORDS = 500;

  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall;
  in_t  in_data;
  out_t out_data;
  int   fail_count, pending, idle_cycles, accepted;
  logic no_idle;
  in_t  directed_q[$];

  interval_arithmetic_alu_top i_dut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .in_data_i(in_data), .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_data_o(out_data)
  );

  interval_arithmetic_alu_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .in_data_i(in_data), .out_valid_i(out_valid), .out_stall_i(out_stall),
    .out_data_i(out_data), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic val_t rand_val();
    case ($urandom_range(0, 7))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return val_t'($urandom_range(0, 6)) - 3;
      3: return val_t'($signed($urandom_range(0, 200)) - 100);
      4: return val_t'($signed($urandom_range(0, 131072)) - 65536);
      default: return val_t'($urandom());
    endcase
  endfunction

  function automatic in_t make_word(input logic [2:0] k, input val_t al, input val_t ah,
                                    input val_t bl, input val_t bh);
    in_t w;
    w.kind = k; w.a_low = al; w.a_high = ah; w.b_low = bl; w.b_high = bh;
    return w;
  endfunction

  always_ff @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      idle_cycles <= 0;
    end else begin
      out_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 35);
      idle_cycles <= (in_valid && !in_stall) || (out_valid && !out_stall) ? 0
                     : idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Leaves valid high after acceptance; the caller drops it, or the next call idles or drives a new word.
  task automatic send_word(input in_t w);
    while (!no_idle && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    in_t w;
    logic [2:0] k;
    val_t a;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; no_idle = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int kk = 0; kk < 8; kk++)
      directed_q.push_back(make_word(3'(kk), VAL_MAX, VAL_MIN, 5, -3));
    directed_q.push_back(make_word(KIND_ADD, VAL_MAX, VAL_MAX, VAL_MAX, 1));
    directed_q.push_back(make_word(KIND_SUB, VAL_MIN, VAL_MIN, VAL_MAX, VAL_MAX));
    directed_q.push_back(make_word(KIND_MUL, VAL_MIN, VAL_MAX, VAL_MIN, -1));
    directed_q.push_back(make_word(KIND_MUL, VAL_MIN, 0, 1, -1));
    directed_q.push_back(make_word(KIND_DIV, VAL_MIN, 7, -1, -1));
    directed_q.push_back(make_word(KIND_DIV, -7, 100, 0, 0));
    directed_q.push_back(make_word(KIND_DIV, 100, -7, 3, -3));
    directed_q.push_back(make_word(KIND_DIV, -100, 99, 7, 3));
    directed_q.push_back(make_word(KIND_NEG, VAL_MIN, VAL_MIN, 0, 0));
    directed_q.push_back(make_word(KIND_ABS, VAL_MIN, 3, 9, 9));
    directed_q.push_back(make_word(KIND_ABS, -9, -2, 0, 0));
    directed_q.push_back(make_word(KIND_ABS, -5, 8, 0, 0));
    directed_q.push_back(make_word(KIND_ABS, 2, 4, VAL_MIN, VAL_MAX));
    directed_q.push_back(make_word(KIND_MUL, 0, 0, -1, 0));
    directed_q.push_back(make_word(3'd7, '1, '1, '1, '1));
    foreach (directed_q[i]) send_word(directed_q[i]);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      no_idle = (i >= 150 && i < 250);
      k = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                        : 3'($urandom_range(KIND_ADD, KIND_ABS));
      w = make_word(k, rand_val(), rand_val(), rand_val(), rand_val());
      if (i % 5 == 0) begin
        a = val_t'($urandom());
        w.b_low = a; w.b_high = ~a;
      end
      send_word(w);
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
